// ----- design/sebfr_pkg.sv -----
// Package for the STX/ETX frame receiver with XOR block check.
// Holds frame codes, register reset values, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package sebfr_pkg;

    localparam logic [7:0] STX_CODE    = 8'h02;
    localparam logic [7:0] ETX_CODE    = 8'h03;
    localparam logic [7:0] RESET_DATA  = 8'hFF;
    localparam logic [7:0] GAP_MAX     = 8'hFF;
    localparam logic [7:0] LENGTH_MAX  = 8'hFF;
    localparam int         FRAME_SLOTS = 7;

    localparam logic [7:0] STATION_ID_RESET   = 8'd1;
    localparam logic [7:0] BROADCAST_ID_RESET = 8'd33;
    localparam logic [7:0] GAP_LIMIT_RESET    = 8'd3;
    localparam int         MAX_COUNT_DEFAULT  = 255;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        CFG_STATION_ID   = 2'd0,
        CFG_BROADCAST_ID = 2'd1,
        CFG_GAP_LIMIT    = 2'd2
    } cfg_reg_t;

    typedef logic [FRAME_SLOTS-1:0][7:0] frame_bytes_t;

    typedef struct packed {
        logic [7:0] station_id;
        logic [7:0] broadcast_id;
        logic [7:0] gap_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic       frame_accepted;
        logic       framing_ok;
        logic       address_matched;
        logic       check_matched;
        logic       reset_request;
        logic [7:0] frame_length;
    } judge_result_t;

endpackage

// ----- design/stx_etx_bcc_frame_receiver.sv -----
// Top level of the STX/ETX frame receiver with XOR block check.
// Holds the configuration registers and the result register.
// Depends on sebfr_pkg, sebfr_frame_store and sebfr_judge.
`timescale 1ns / 1ps

// Usage:
// The s_ channel carries one item per handshake: s_tuser says whether it is a
// received byte (0) or a time tick (1), s_tdata[7:0] holds the byte.
// Bytes are dropped until STX; then every byte is counted and the first seven
// are stored. Ticks raise the idle-gap counter; the tick on which the gap
// reaches gap_limit while a frame is pending judges the frame and emits one
// result item on the m_ channel. All other items give no result.
// Throughput: one item per cycle while no result is stalled. The result is
// valid in the cycle after the judging tick is accepted; the checks run
// between the frame store and the result register.
// A stalled m_ side holds the result; s_tready then drops until the result
// is taken, and rises again in the same cycle that m_tready takes it.
// Reset (aresetn low at a clock edge) clears the frame store, the counters
// and the result valid flag, and loads the register defaults
// (station_id 1, broadcast_id 33, gap_limit 3).
// Write registers through cfg_wr_en/cfg_addr/cfg_wr_data while idle only.

module stx_etx_bcc_frame_receiver
    import sebfr_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] frame_accepted, [1] framing_ok, [2] address_matched,
    // [3] check_matched, [4] reset_request, [12:5] frame_length, [15:13] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    cfg_regs_t        cfg_reg, cfg_next;
    logic             m_valid_reg, m_valid_next;
    judge_result_t    result_reg, result_next;
    judge_result_t    judged;
    frame_bytes_t     frame_bytes;
    logic [CNT_W-1:0] byte_count;
    logic             judge_fire;
    logic             s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_STATION_ID:   cfg_next.station_id   = cfg_wr_data;
                CFG_BROADCAST_ID: cfg_next.broadcast_id = cfg_wr_data;
                CFG_GAP_LIMIT:    cfg_next.gap_limit    = cfg_wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    sebfr_frame_store #(
        .MAX_COUNT(MAX_COUNT)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_accept),
        .item_kind  (s_tuser),
        .item_byte  (s_tdata),
        .gap_limit  (cfg_reg.gap_limit),
        .frame_bytes(frame_bytes),
        .byte_count (byte_count),
        .judge_fire (judge_fire)
    );

    sebfr_judge #(
        .MAX_COUNT(MAX_COUNT)
    ) u_judge (
        .frame_bytes(frame_bytes),
        .byte_count (byte_count),
        .cfg        (cfg_reg),
        .result     (judged)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        if (judge_fire) begin
            m_valid_next = 1'b1;
            result_next  = judged;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.station_id   <= STATION_ID_RESET;
            cfg_reg.broadcast_id <= BROADCAST_ID_RESET;
            cfg_reg.gap_limit    <= GAP_LIMIT_RESET;
            m_valid_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, result_reg.frame_length, result_reg.reset_request,
                       result_reg.check_matched, result_reg.address_matched,
                       result_reg.framing_ok, result_reg.frame_accepted};

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        judge_fire |=> m_tvalid)
        else $error("judged frame gave no result item");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result is stalled");

    a_fire_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        judge_fire |=> (byte_count == '0))
        else $error("frame store not cleared after judging");

    a_accept_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || (m_tdata[1] && m_tdata[2] && m_tdata[3])))
        else $error("frame accepted without all checks passing");

    a_reset_needs_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[4] || m_tdata[0]))
        else $error("reset request on a rejected frame");

endmodule

// ----- design/sebfr_frame_store.sv -----
// Frame store: first seven bytes, saturating byte count and idle-gap counter.
// Raises the judge strobe on the tick that closes a frame.
// Depends on sebfr_pkg.
`timescale 1ns / 1ps

module sebfr_frame_store
    import sebfr_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEFAULT,
    localparam int CNT_W = $clog2(MAX_COUNT + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  logic             item_kind,
    input  logic [7:0]       item_byte,
    input  logic [7:0]       gap_limit,
    output frame_bytes_t     frame_bytes,
    output logic [CNT_W-1:0] byte_count,
    output logic             judge_fire
);

    localparam logic [CNT_W-1:0] COUNT_TOP = CNT_W'(MAX_COUNT);

    frame_bytes_t     bytes_reg, bytes_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       gap_reg, gap_next;
    logic [7:0]       gap_inc;

    assign gap_inc    = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 8'd1;
    assign judge_fire = item_valid && (item_kind == REQ_TICK) &&
                        (count_reg != '0) && (gap_inc >= gap_limit);

    always_comb begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        gap_next   = gap_reg;
        if (item_valid) begin
            if (item_kind == REQ_BYTE) begin
                gap_next = '0;
                if (count_reg == '0) begin
                    if (item_byte == STX_CODE) begin
                        bytes_next[0] = item_byte;
                        count_next    = CNT_W'(1);
                    end
                end else begin
                    for (int i = 1; i < FRAME_SLOTS; i++) begin
                        if (count_reg == CNT_W'(i)) begin
                            bytes_next[i] = item_byte;
                        end
                    end
                    if (count_reg < COUNT_TOP) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end else begin
                gap_next = gap_inc;
                if (judge_fire) begin
                    gap_next   = '0;
                    count_next = '0;
                    bytes_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
            count_reg <= '0;
            gap_reg   <= '0;
        end else begin
            bytes_reg <= bytes_next;
            count_reg <= count_next;
            gap_reg   <= gap_next;
        end
    end

    assign frame_bytes = bytes_reg;
    assign byte_count  = count_reg;

endmodule

// ----- design/sebfr_judge.sv -----
// Frame judge: framing, address, XOR block check and reset-command decode.
// Pure combinational checks on the stored frame.
// Depends on sebfr_pkg.
`timescale 1ns / 1ps

module sebfr_judge
    import sebfr_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEFAULT,
    localparam int CNT_W = $clog2(MAX_COUNT + 1)
) (
    input  frame_bytes_t     frame_bytes,
    input  logic [CNT_W-1:0] byte_count,
    input  cfg_regs_t        cfg,
    output judge_result_t    result
);

    logic [7:0]         chk;
    logic [CNT_W+7:0]   count_ext;
    logic               framing, addr, check, accept;

    always_comb begin
        chk = '0;
        for (int i = 0; i < FRAME_SLOTS - 1; i++) begin
            chk = chk ^ frame_bytes[i];
        end
    end

    assign count_ext = {8'd0, byte_count};
    assign framing   = (frame_bytes[0] == STX_CODE) && (frame_bytes[5] == ETX_CODE);
    assign addr      = (frame_bytes[1] == cfg.station_id) ||
                       (frame_bytes[1] == cfg.broadcast_id);
    assign check     = (chk == frame_bytes[6]);
    assign accept    = framing && addr && check;

    always_comb begin
        result.frame_accepted  = accept;
        result.framing_ok      = framing;
        result.address_matched = addr;
        result.check_matched   = check;
        result.reset_request   = accept && (frame_bytes[2] == RESET_DATA) &&
                                 (frame_bytes[3] == RESET_DATA) &&
                                 (frame_bytes[4] == RESET_DATA);
        result.frame_length    = (count_ext > {{CNT_W{1'b0}}, LENGTH_MAX}) ?
                                 LENGTH_MAX : count_ext[7:0];
    end

endmodule
